/* rtl/md4_pkg.sv */
// Package with the shared types, constants and step functions of the MD4 digest block.
`timescale 1ns / 1ps

package md4_pkg;

   localparam int unsigned STEPS = 48;
   localparam int unsigned BLOCK_WORDS = 16;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] K2 = 32'h5a827999;
   localparam logic [31:0] K3 = 32'h6ed9eba1;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_SWEEP,
      ST_COMPRESS,
      ST_ADD,
      ST_OUT
   } state_type;

   // What follows a finished compression.
   typedef enum logic [1:0] {
      AFTER_IDLE,
      AFTER_PAD,
      AFTER_LENGTH,
      AFTER_OUT
   } after_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } abcd_type;

   // Message word used by a step: plain order, then column order, then bit-reversed order.
   function automatic logic [3:0] word_order(input logic [5:0] step);
      logic [3:0] s;
      logic [3:0] w;
      s = step[3:0];
      unique case (step[5:4])
         2'd1: w = {s[1:0], s[3:2]};
         2'd2: w = {s[0], s[1], s[2], s[3]};
         default: w = s;
      endcase
      return w;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [1:0] round, input logic [1:0] s);
      logic [4:0] r;
      unique case (round)
         2'd0: begin
            unique case (s)
               2'd0: r = 5'd3;
               2'd1: r = 5'd7;
               2'd2: r = 5'd11;
               default: r = 5'd19;
            endcase
         end
         2'd1: begin
            unique case (s)
               2'd0: r = 5'd3;
               2'd1: r = 5'd5;
               2'd2: r = 5'd9;
               default: r = 5'd13;
            endcase
         end
         default: begin
            unique case (s)
               2'd0: r = 5'd3;
               2'd1: r = 5'd9;
               2'd2: r = 5'd11;
               default: r = 5'd15;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

/* rtl/md4_step.sv */
// One MD4 compression step: round function, additions and rotation.
`timescale 1ns / 1ps

module md4_step (
   input  md4_pkg::abcd_type cur,
   input  logic [31:0]       x,
   input  logic [5:0]        step,
   output md4_pkg::abcd_type nxt
);

   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] t;

   always_comb begin
      unique case (step[5:4])
         2'd0: begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = 32'd0;
         end
         2'd1: begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = md4_pkg::K2;
         end
         default: begin
            f = cur.b ^ cur.c ^ cur.d;
            k = md4_pkg::K3;
         end
      endcase
      t = cur.a + f + x + k;
      nxt.a = cur.d;
      nxt.d = cur.c;
      nxt.c = cur.b;
      nxt.b = md4_pkg::rotl32(t, md4_pkg::rot_amount(step[5:4], step[1:0]));
   end

endmodule

/* rtl/md4_message_digest.sv */
// MD4 message digest: byte input, block store in memory, 48-step compression, digest output.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one word per accepted item: a message byte (req_data_byte,
// valid when req_has_byte is set) and req_is_last, which closes the message. A last
// item may carry no byte, so the empty message can be hashed.
// Bytes go straight into a 16-entry block memory; a byte is taken every cycle until
// 64 have gathered. The 64th byte starts a compression (a read-ahead memory read,
// 48 steps at one memory read each, and a chaining add) while req_stall is high.
// On a last item the block writes the pad byte, sweeps zero fill and the bit length
// into the memory one word a cycle (at most 16 words, after which it starts the
// compression), and compresses once, or twice when fewer than eight bytes of room are
// left. The four digest words then appear on the rsp channel, word 0 first, with
// rsp_last_word on word 3; taking word 3 restores the initial chaining values and the
// block accepts the next message.
// req_stall stays high from a last item until the final word is taken, so a stalling
// receiver simply holds the block with the current word on rsp_digest_word.
// Synchronous reset loads the initial chaining values and clears the byte count; the
// block memory needs no clearing since every word is written before it is read.

module md4_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   md4_pkg::state_type state_ff, state_in;
   md4_pkg::after_type after_ff, after_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [60:0] count_ff, count_in;
   logic [31:0] word_ff, word_in;
   logic [4:0]  ptr_ff, ptr_in;
   logic        length_pass_ff, length_pass_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  idx_ff, idx_in;
   md4_pkg::abcd_type abcd_ff, abcd_in, abcd_step;

   logic [31:0] block_mem [md4_pkg::BLOCK_WORDS];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [3:0]  mem_waddr;
   logic [31:0] mem_wdata;
   logic [3:0]  mem_raddr;

   logic        req_accept;
   logic        rsp_accept;
   logic [5:0]  pos;
   logic [5:0]  step_done;
   logic [31:0] byte_shifted;
   logic [31:0] pad_shifted;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign pos = count_ff[5:0];
   assign step_done = cnt_ff - 6'd1;
   assign byte_shifted = {24'd0, req_data_byte} << {pos[1:0], 3'b000};
   assign pad_shifted = {24'd0, md4_pkg::PAD_BYTE} << {pos[1:0], 3'b000};
   assign mem_raddr = md4_pkg::word_order(cnt_ff);

   md4_step u_step (
      .cur  (abcd_ff),
      .x    (rdata_ff),
      .step (step_done),
      .nxt  (abcd_step)
   );

   // Byte, pad and sweep writes all happen before compression starts, so no read
   // that a step uses meets a write to the same word in one cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         block_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= block_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md4_pkg::ST_IDLE;
         after_ff <= md4_pkg::AFTER_IDLE;
         chain_ff[0] <= md4_pkg::IV0;
         chain_ff[1] <= md4_pkg::IV1;
         chain_ff[2] <= md4_pkg::IV2;
         chain_ff[3] <= md4_pkg::IV3;
         count_ff <= '0;
         ptr_ff <= '0;
         length_pass_ff <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         length_pass_ff <= length_pass_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      word_ff <= word_in;
      abcd_ff <= abcd_in;
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      word_in = word_ff;
      ptr_in = ptr_ff;
      length_pass_in = length_pass_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      abcd_in = abcd_ff;
      mem_we = 1'b0;
      mem_waddr = pos[5:2];
      mem_wdata = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         md4_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               if (req_has_byte) begin
                  // The first byte of a word clears it; later lanes only OR in.
                  word_in = (pos[1:0] == 2'd0) ? byte_shifted : (word_ff | byte_shifted);
                  mem_we = 1'b1;
                  mem_wdata = word_in;
                  count_in = count_ff + 61'd1;
                  if (pos == 6'd63) begin
                     state_in = md4_pkg::ST_COMPRESS;
                     cnt_in = '0;
                     after_in = req_is_last ? md4_pkg::AFTER_PAD : md4_pkg::AFTER_IDLE;
                  end else if (req_is_last) begin
                     state_in = md4_pkg::ST_PAD;
                  end
               end else if (req_is_last) begin
                  state_in = md4_pkg::ST_PAD;
               end
            end
         end

         md4_pkg::ST_PAD: begin
            mem_we = 1'b1;
            mem_wdata = (pos[1:0] == 2'd0) ? pad_shifted : (word_ff | pad_shifted);
            ptr_in = {1'b0, pos[5:2]} + 5'd1;
            length_pass_in = (pos < 6'd56);
            state_in = md4_pkg::ST_SWEEP;
         end

         md4_pkg::ST_SWEEP: begin
            if (ptr_ff[4]) begin
               state_in = md4_pkg::ST_COMPRESS;
               cnt_in = '0;
               after_in = length_pass_ff ? md4_pkg::AFTER_OUT : md4_pkg::AFTER_LENGTH;
            end else begin
               mem_we = 1'b1;
               mem_waddr = ptr_ff[3:0];
               if (length_pass_ff && ptr_ff[3:0] == 4'd14) begin
                  mem_wdata = {count_ff[28:0], 3'b000};
               end else if (length_pass_ff && ptr_ff[3:0] == 4'd15) begin
                  mem_wdata = count_ff[60:29];
               end
               ptr_in = ptr_ff + 5'd1;
            end
         end

         md4_pkg::ST_COMPRESS: begin
            // The read for step n is issued while step n-1 uses the word read before.
            if (cnt_ff == 6'd0) begin
               abcd_in = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2], d: chain_ff[3]};
            end else begin
               abcd_in = abcd_step;
            end
            if (cnt_ff == 6'(md4_pkg::STEPS)) begin
               state_in = md4_pkg::ST_ADD;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         md4_pkg::ST_ADD: begin
            chain_in[0] = chain_ff[0] + abcd_ff.a;
            chain_in[1] = chain_ff[1] + abcd_ff.b;
            chain_in[2] = chain_ff[2] + abcd_ff.c;
            chain_in[3] = chain_ff[3] + abcd_ff.d;
            unique case (after_ff)
               md4_pkg::AFTER_IDLE: state_in = md4_pkg::ST_IDLE;
               md4_pkg::AFTER_PAD: state_in = md4_pkg::ST_PAD;
               md4_pkg::AFTER_LENGTH: begin
                  ptr_in = '0;
                  length_pass_in = 1'b1;
                  state_in = md4_pkg::ST_SWEEP;
               end
               default: begin
                  idx_in = '0;
                  state_in = md4_pkg::ST_OUT;
               end
            endcase
         end

         md4_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_accept) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in[0] = md4_pkg::IV0;
                  chain_in[1] = md4_pkg::IV1;
                  chain_in[2] = md4_pkg::IV2;
                  chain_in[3] = md4_pkg::IV3;
                  count_in = '0;
                  state_in = md4_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = md4_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index = idx_ff;
   assign rsp_last_word = (idx_ff == 2'd3);

`ifndef NO_ASSERTIONS
   a_restart_iv: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_word) |=>
         (chain_ff[0] == md4_pkg::IV0 && chain_ff[3] == md4_pkg::IV3 && count_ff == '0))
      else $error("chaining state not restored after the final digest word");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md4_pkg::ST_COMPRESS) |-> (cnt_ff <= 6'(md4_pkg::STEPS)))
      else $error("step counter ran past the last step");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md4_pkg::ST_SWEEP) |-> (ptr_ff <= 5'd16))
      else $error("sweep pointer ran past the block");

   a_no_write_in_compress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md4_pkg::ST_COMPRESS) |-> !mem_we)
      else $error("block memory written during compression");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the MD4 digest block: directed and random messages.
`timescale 1ns / 1ps

module tb;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] ROUND2_ADD = 32'h5a827999;
   localparam logic [31:0] ROUND3_ADD = 32'h6ed9eba1;
   localparam logic [7:0] PAD_MARK = 8'h80;
   // Byte j of each constant is the rotate amount of step j mod 4 in that round.
   localparam logic [31:0] ROUND1_ROT = 32'h130b0703;
   localparam logic [31:0] ROUND2_ROT = 32'h0d090503;
   localparam logic [31:0] ROUND3_ROT = 32'h0f0b0903;
   // Nibble i holds i with its four bits reversed (round three word order).
   localparam logic [63:0] BIT_REVERSED = 64'hf7b3d591e6a2c480;
   localparam int STALL_PERCENT = 27;
   localparam int HANG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 150;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  slot;
      logic        closing;
   } digest_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   // Predictor state: chaining words, block store and running byte count.
   logic [31:0] chain [4];
   logic [31:0] block_store [16];
   logic [60:0] bytes_hashed;

   digest_word_t digest_words_due [$];
   int mismatch_count = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;

   md4_message_digest dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_has_byte(req_has_byte),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int amount);
      return (v << amount) | (v >> (32 - amount));
   endfunction

   function automatic int message_word(input int round, input int step);
      if (round == 0) begin
         return step;
      end else if (round == 1) begin
         return (step % 4) * 4 + step / 4;
      end
      return int'(BIT_REVERSED[step * 4 +: 4]);
   endfunction

   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, k, t, rots;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int round = 0; round < 3; round++) begin
         for (int step = 0; step < 16; step++) begin
            case (round)
               0: begin
                  f = (b & c) | (~b & d);
                  k = 32'h0;
                  rots = ROUND1_ROT;
               end
               1: begin
                  f = (b & c) | (b & d) | (c & d);
                  k = ROUND2_ADD;
                  rots = ROUND2_ROT;
               end
               default: begin
                  f = b ^ c ^ d;
                  k = ROUND3_ADD;
                  rots = ROUND3_ROT;
               end
            endcase
            t = a + f + block_store[message_word(round, step)] + k;
            t = rotate_left(t, int'(rots[(step % 4) * 8 +: 8]));
            a = d;
            d = c;
            c = b;
            b = t;
         end
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
   endfunction

   function automatic void start_message();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      bytes_hashed = '0;
   endfunction

   function automatic void store_byte(input logic [5:0] pos, input logic [7:0] b);
      if (pos[1:0] == 2'd0) begin
         block_store[pos[5:2]] = {24'h0, b};
      end else begin
         block_store[pos[5:2]][pos[1:0] * 8 +: 8] = b;
      end
   endfunction

   // Advances the digest state by one accepted word and queues any digest words.
   function automatic void hash_word(input logic [7:0] b, input logic has, input logic last);
      logic [5:0] pos;
      logic [63:0] bit_length;
      digest_word_t w;
      if (has) begin
         pos = bytes_hashed[5:0];
         store_byte(pos, b);
         bytes_hashed = bytes_hashed + 61'd1;
         if (pos == 6'd63) begin
            compress_block();
         end
      end
      if (last) begin
         pos = bytes_hashed[5:0];
         store_byte(pos, PAD_MARK);
         for (int i = pos[5:2] + 1; i < 16; i++) begin
            block_store[i] = 32'h0;
         end
         // With fewer than eight bytes left there is no room for the length.
         if (pos >= 6'd56) begin
            compress_block();
            for (int i = 0; i < 16; i++) begin
               block_store[i] = 32'h0;
            end
         end
         bit_length = {bytes_hashed, 3'b000};
         block_store[14] = bit_length[31:0];
         block_store[15] = bit_length[63:32];
         compress_block();
         for (int i = 0; i < 4; i++) begin
            w.value = chain[i];
            w.slot = 2'(i);
            w.closing = (i == 3);
            digest_words_due.push_back(w);
         end
         start_message();
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic has, input logic last);
      while (!no_idle && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_has_byte <= has;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      hash_word(b, has, last);
      items_sent++;
   endtask

   task automatic send_message(input int len, input bit byte_on_last);
      for (int i = 0; i < len; i++) begin
         // Now and then a word that carries nothing.
         if ($urandom_range(9) == 0) begin
            send_word(8'($urandom), 1'b0, 1'b0);
         end
         send_word(8'($urandom), 1'b1, byte_on_last && (i == len - 1));
      end
      if (!byte_on_last || len == 0) begin
         send_word(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic test_empty_message();
      send_word(8'hff, 1'b0, 1'b1);
   endtask

   task automatic test_byte_with_last();
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
   endtask

   task automatic test_empty_words();
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h63, 1'b1, 1'b0);
      send_word(8'ha5, 1'b0, 1'b1);
   endtask

   task automatic test_short_message();
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h7f, 1'b1, 1'b0);
      send_word(8'h01, 1'b1, 1'b0);
      send_word(8'hfe, 1'b1, 1'b1);
   endtask

   // Mostly short messages; the rest sit on the padding and block edges.
   task automatic test_random_messages();
      int edge_lengths [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      int messages;
      int len;
      messages = 0;
      while (items_sent < 250 || messages < 8) begin
         no_idle = (messages >= 4 && messages < 8);
         if ($urandom_range(99) < 20) begin
            len = edge_lengths[$urandom_range(8)];
         end else begin
            len = $urandom_range(24);
         end
         send_message(len, 1'($urandom_range(1)));
         messages++;
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < STALL_PERCENT);
      end
   end

   always @(posedge clock) begin
      digest_word_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected digest word %h index %0d last %b",
                        rsp_digest_word, rsp_word_index, rsp_last_word);
            end
         end else begin
            e = digest_words_due.pop_front();
            if (rsp_digest_word !== e.value || rsp_word_index !== e.slot
                || rsp_last_word !== e.closing) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("digest word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           e.value, e.slot, e.closing,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      start_message();
      for (int i = 0; i < 16; i++) begin
         block_store[i] = 32'h0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_with_last();
      test_empty_words();
      test_short_message();
      test_random_messages();
      req_valid <= 1'b0;
      while (digest_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_words_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
